FILE: rtl/cpr_pkg.sv
package cpr_pkg;

   localparam int FRAMES        = 1024;
   localparam int PAGE_BITS     = 20;
   localparam int IDX_W         = $clog2(FRAMES);
   localparam int CNT_W         = $clog2(FRAMES + 1);
   localparam int MOD_CNT_W     = $clog2(IDX_W + 1);
   localparam int CSR_W         = 11;
   localparam int PAGE_ID_W     = 20;
   localparam int FRAME_INDEX_W = 10;

   typedef struct packed {
      logic                 valid;
      logic                 ref_bit;
      logic [PAGE_BITS-1:0] page;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic clear_step;
      logic take_req;
      logic search_step;
      logic mod_start;
      logic sweep_init;
      logic sweep_read;
      logic sweep_check;
      logic load;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic search_done;
      logic found;
      logic mod_ready;
      logic sweep_ref;
      logic rsp_free;
   } sts_type;

   // A count of zero means one frame; anything above the built depth saturates.
   function automatic logic [CNT_W-1:0] active_count(input logic [CSR_W-1:0] value);
      logic [CSR_W+CNT_W-1:0] wide;
      wide = {{CNT_W{1'b0}}, value};
      if (value == '0) begin
         return CNT_W'(1);
      end else if (wide > (CSR_W + CNT_W)'(FRAMES)) begin
         return CNT_W'(FRAMES);
      end else begin
         return wide[CNT_W-1:0];
      end
   endfunction

endpackage

FILE: rtl/cpr_ram.sv
module cpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/cpr_mod.sv
module cpr_mod
   import cpr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [IDX_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             ready,
   output logic [IDX_W-1:0] remainder
);

   logic                 ready_ff, ready_in;
   logic [MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [IDX_W-1:0]     dvd_ff, dvd_in;
   logic [CNT_W:0]       shifted;
   logic [CNT_W:0]       diff;

   // Restoring remainder, one dividend bit per cycle.
   assign shifted = {rem_ff, dvd_ff[IDX_W-1]};
   assign diff    = shifted - {1'b0, divisor};

   always_comb begin
      ready_in = ready_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      if (start) begin
         ready_in = 1'b0;
         cnt_in   = MOD_CNT_W'(IDX_W);
         rem_in   = '0;
         dvd_in   = dividend;
      end else if (!ready_ff) begin
         if (shifted >= {1'b0, divisor}) begin
            rem_in = diff[CNT_W-1:0];
         end else begin
            rem_in = shifted[CNT_W-1:0];
         end
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - MOD_CNT_W'(1);
         if (cnt_ff == MOD_CNT_W'(1)) begin
            ready_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b1;
         cnt_ff   <= '0;
      end else begin
         ready_ff <= ready_in;
         cnt_ff   <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign ready     = ready_ff;
   assign remainder = rem_ff[IDX_W-1:0];

endmodule

FILE: rtl/cpr_datapath.sv
module cpr_datapath
   import cpr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output sts_type                  sts,
   input  logic [PAGE_ID_W-1:0]     req_page_id,
   input  logic                     csr_wr_en,
   input  logic [CSR_W-1:0]         csr_frame_count,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_hit,
   output logic [FRAME_INDEX_W-1:0] rsp_frame_index
);

   logic [CNT_W-1:0]     n_ff, n_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]     chk_addr_ff, chk_addr_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     where_ff, where_in;
   logic [IDX_W-1:0]     hand_ff, hand_in;
   logic [IDX_W-1:0]     h_ff, h_in;
   logic [IDX_W-1:0]     clr_idx_ff, clr_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic [FRAME_INDEX_W-1:0] rsp_idx_ff, rsp_idx_in;

   logic [PAGE_BITS+PAGE_ID_W-1:0]   page_wide;
   logic [IDX_W+FRAME_INDEX_W-1:0]   where_wide;
   logic [CNT_W-1:0]     h_plus;
   logic [IDX_W-1:0]     h_next;
   logic                 issue;
   logic                 match;
   logic                 mod_ready;
   logic [IDX_W-1:0]     mod_rem;

   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   entry_type            ram_wr_data;
   logic                 ram_rd_en;
   logic [IDX_W-1:0]     ram_rd_addr;
   entry_type            ram_rd_data;

   cpr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (FRAMES)
   ) u_frames (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   cpr_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (hand_ff),
      .divisor   (n_ff),
      .ready     (mod_ready),
      .remainder (mod_rem)
   );

   assign page_wide  = {{PAGE_BITS{1'b0}}, req_page_id};
   assign where_wide = {{FRAME_INDEX_W{1'b0}}, where_ff};

   // The search issues one read a cycle; each compare runs in the cycle after its read.
   assign issue = cmd.search_step && (idx_ff < n_ff);
   assign match = cmd.search_step && chk_vld_ff && ram_rd_data.valid &&
                  (ram_rd_data.page == page_ff);

   assign h_plus = CNT_W'(h_ff) + CNT_W'(1);
   assign h_next = (h_plus == n_ff) ? '0 : h_plus[IDX_W-1:0];

   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = h_ff;
      if (issue) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = idx_ff[IDX_W-1:0];
      end else if (cmd.sweep_read) begin
         ram_rd_en = 1'b1;
      end
   end

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = h_ff;
      ram_wr_data = '{valid: 1'b1, ref_bit: 1'b1, page: page_ff};
      if (cmd.clear_step) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_idx_ff;
         ram_wr_data = '0;
      end else if (match) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = chk_addr_ff;
      end else if (cmd.sweep_check && ram_rd_data.ref_bit) begin
         ram_wr_en   = 1'b1;
         ram_wr_data = '{valid: ram_rd_data.valid, ref_bit: 1'b0, page: ram_rd_data.page};
      end else if (cmd.load) begin
         ram_wr_en = 1'b1;
      end
   end

   always_comb begin
      n_in        = csr_wr_en ? active_count(csr_frame_count) : n_ff;
      page_in     = page_ff;
      idx_in      = idx_ff;
      chk_vld_in  = issue;
      chk_addr_in = idx_ff[IDX_W-1:0];
      found_in    = found_ff;
      where_in    = where_ff;
      hand_in     = hand_ff;
      h_in        = h_ff;
      clr_idx_in  = clr_idx_ff;
      rsp_hit_in  = rsp_hit_ff;
      rsp_idx_in  = rsp_idx_ff;

      if (cmd.clear_step) begin
         clr_idx_in = clr_idx_ff + IDX_W'(1);
      end
      if (cmd.take_req) begin
         page_in  = page_wide[PAGE_BITS-1:0];
         idx_in   = '0;
         found_in = 1'b0;
      end
      if (issue) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (match && !found_ff) begin
         found_in = 1'b1;
         where_in = chk_addr_ff;
      end
      if (cmd.sweep_init) begin
         h_in = mod_rem;
      end
      if (cmd.sweep_check && ram_rd_data.ref_bit) begin
         h_in = h_next;
      end
      if (cmd.load) begin
         where_in = h_ff;
         hand_in  = h_next;
      end
      if (cmd.rsp_load) begin
         rsp_hit_in = found_ff;
         rsp_idx_in = where_wide[FRAME_INDEX_W-1:0];
      end
      rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= CNT_W'(FRAMES);
         idx_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         hand_ff      <= '0;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         n_ff         <= n_in;
         idx_ff       <= idx_in;
         chk_vld_ff   <= chk_vld_in;
         found_ff     <= found_in;
         hand_ff      <= hand_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      page_ff     <= page_in;
      chk_addr_ff <= chk_addr_in;
      where_ff    <= where_in;
      h_ff        <= h_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_idx_ff  <= rsp_idx_in;
   end

   assign sts.clear_last  = (clr_idx_ff == IDX_W'(FRAMES - 1));
   assign sts.search_done = !(idx_ff < n_ff) && !chk_vld_ff;
   assign sts.found       = found_ff;
   assign sts.mod_ready   = mod_ready;
   assign sts.sweep_ref   = ram_rd_data.ref_bit;
   assign sts.rsp_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_frame_index = rsp_idx_ff;

endmodule

FILE: rtl/cpr_ctrl.sv
module cpr_ctrl
   import cpr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [6:0] {
      S_CLEAR     = 7'b0000001,
      S_IDLE      = 7'b0000010,
      S_SEARCH    = 7'b0000100,
      S_MOD       = 7'b0001000,
      S_SWEEP_RD  = 7'b0010000,
      S_SWEEP_CHK = 7'b0100000,
      S_DONE      = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_req = 1'b1;
               state_in     = S_SEARCH;
            end
         end
         S_SEARCH: begin
            cmd.search_step = 1'b1;
            if (sts.search_done) begin
               if (sts.found) begin
                  state_in = S_DONE;
               end else begin
                  cmd.mod_start = 1'b1;
                  state_in      = S_MOD;
               end
            end
         end
         S_MOD: begin
            if (sts.mod_ready) begin
               cmd.sweep_init = 1'b1;
               state_in       = S_SWEEP_RD;
            end
         end
         S_SWEEP_RD: begin
            cmd.sweep_read = 1'b1;
            state_in       = S_SWEEP_CHK;
         end
         S_SWEEP_CHK: begin
            cmd.sweep_check = 1'b1;
            if (sts.sweep_ref) begin
               state_in = S_SWEEP_RD;
            end else begin
               cmd.load = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

FILE: rtl/clock_page_replacement.sv
// Clock (second-chance) page replacement over FRAMES physical frames.
// Request channel: req_valid / req_stall carry one page reference (req_page_id).
// Response channel: rsp_valid / rsp_stall carry rsp_hit and rsp_frame_index,
// the frame that holds the page once the reference has been handled.
// csr_wr_en writes csr_frame_count, the number of frames in use; write it only
// while no transaction is in flight.
// After reset the frame table is cleared one entry per cycle, every entry,
// with req_stall high; the frame count returns to FRAMES and the hand to zero.
// One reference is handled at a time. The frame table is a single RAM with a
// registered read, so the search reads one frame a cycle, n frames in all,
// n being the active frame count. A miss then reduces the hand modulo n and
// sweeps from there; the hand visits up to n + 1 frames.
// The next request can be accepted in the cycle after the response is loaded.
// The response sits in an output register, so the next request is accepted
// while a response is stalled; that request finishes its search and then
// waits until the register frees up.
module clock_page_replacement
   import cpr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [PAGE_ID_W-1:0]     req_page_id,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_hit,
   output logic [FRAME_INDEX_W-1:0] rsp_frame_index,
   input  logic                     csr_wr_en,
   input  logic [CSR_W-1:0]         csr_frame_count
);

   cmd_type cmd;
   sts_type sts;

   cpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cpr_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_page_id     (req_page_id),
      .csr_wr_en       (csr_wr_en),
      .csr_frame_count (csr_frame_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_frame_index (rsp_frame_index)
   );

   // An accepted request always starts a search in the next cycle.
   a_accept_starts_search: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> cmd.search_step)
      else $error("accepted request did not start a search");

   // A response is only loaded when the output register is free.
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid || !rsp_stall))
      else $error("stalled response overwritten");

   // The sweep never begins before the hand has been reduced.
   a_sweep_after_mod: assert property (@(posedge clock) disable iff (reset)
      (cmd.sweep_init || cmd.sweep_read) |-> sts.mod_ready)
      else $error("sweep started with the hand reduction in progress");

endmodule

FILE: sim/clock_page_replacement_tb.sv
`timescale 1ns / 100ps

module clock_page_replacement_tb;
   import cpr_pkg::*;

   typedef struct packed {
      bit                     hit;
      bit [FRAME_INDEX_W-1:0] frame;
   } frame_lookup_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [PAGE_ID_W-1:0]     req_page_id = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_hit;
   logic [FRAME_INDEX_W-1:0] rsp_frame_index;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_W-1:0]         csr_frame_count = '0;

   // Shadow copy of the frame table, the hand and the frame count register.
   bit [PAGE_BITS-1:0] held_page [FRAMES];
   bit                 resident [FRAMES];
   bit                 referenced [FRAMES];
   int unsigned        hand = 0;
   bit [CSR_W-1:0]     shadow_frame_count = CSR_W'(FRAMES);

   frame_lookup_type frame_lookups_due[$];
   frame_lookup_type oldest;
   int unsigned   mismatch_count = 0;
   int unsigned   rsp_seen = 0;
   int unsigned   send_idle_pct = 0;
   int unsigned   recv_idle_pct = 0;
   logic          hold_rsp = 1'b0;

   clock_page_replacement dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_page_id     (req_page_id),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_frame_index (rsp_frame_index),
      .csr_wr_en       (csr_wr_en),
      .csr_frame_count (csr_frame_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Applies one page reference to the shadow table and returns what the
   // block should report for it.
   function automatic frame_lookup_type predict_reference(bit [PAGE_ID_W-1:0] pid);
      bit [PAGE_BITS-1:0] page;
      int unsigned        n;
      int unsigned        h;
      int unsigned        i;
      frame_lookup_type   res;
      page = PAGE_BITS'(pid);
      n = shadow_frame_count;
      if (n == 0) n = 1;
      if (n > FRAMES) n = FRAMES;
      res.hit = 1'b0;
      res.frame = '0;
      for (i = 0; i < n; i++) begin
         if (resident[i] && held_page[i] == page) begin
            referenced[i] = 1'b1;
            if (!res.hit) begin
               res.hit = 1'b1;
               res.frame = FRAME_INDEX_W'(i);
            end
         end
      end
      if (!res.hit) begin
         // A hand left beyond a shrunk frame count wraps into range first.
         h = hand % n;
         for (i = 0; i <= n && referenced[h]; i++) begin
            referenced[h] = 1'b0;
            h = (h + 1) % n;
         end
         held_page[h] = page;
         resident[h] = 1'b1;
         referenced[h] = 1'b1;
         res.frame = FRAME_INDEX_W'(h);
         hand = (h + 1) % n;
      end
      return res;
   endfunction

   function automatic bit count_mismatch();
      mismatch_count++;
      return mismatch_count <= 10;
   endfunction

   always @(posedge clock) begin
      rsp_stall <= hold_rsp || ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (frame_lookups_due.size() == 0) begin
            if (count_mismatch())
               $display("transaction %0d: response with nothing expected (hit %0d, frame %0d)",
                        rsp_seen, rsp_hit, rsp_frame_index);
         end else begin
            oldest = frame_lookups_due.pop_front();
            if (rsp_hit !== oldest.hit && count_mismatch())
               $display("transaction %0d: hit expected %0d, actual %0d",
                        rsp_seen, oldest.hit, rsp_hit);
            if (rsp_frame_index !== oldest.frame && count_mismatch())
               $display("transaction %0d: frame_index expected %0d, actual %0d",
                        rsp_seen, oldest.frame, rsp_frame_index);
         end
      end
   end

   // Offers one reference and returns at the edge that accepts it, with
   // req_valid still high so back-to-back transactions need no extra edge.
   task automatic send_page(bit [PAGE_ID_W-1:0] pid);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_page_id <= pid;
      do @(posedge clock); while (req_stall !== 1'b0);
      frame_lookups_due.push_back(predict_reference(pid));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (frame_lookups_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_frame_count(bit [CSR_W-1:0] value);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_frame_count <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow_frame_count = value;
      @(posedge clock);
   endtask

   // The reset count of the full depth, with the extreme page numbers.
   task automatic test_full_depth();
      send_page('0);
      send_page('1);
      send_page('0);
      send_page('1);
   endtask

   // Zero behaves as one frame; anything above the depth saturates.
   task automatic test_count_limits();
      write_frame_count('0);
      send_page(20'h00001);
      send_page(20'h00002);
      write_frame_count('1);
      send_page(20'h00002);
      write_frame_count(CSR_W'(1));
      send_page(20'h00007);
   endtask

   // With every bit set the hand goes all the way round and evicts where it began.
   task automatic test_second_chance();
      write_frame_count(CSR_W'(3));
      send_page(20'h55555);
      send_page(20'hAAAAA);
      send_page(20'h0000C);
      send_page(20'hAAAAA);
      send_page(20'h0000D);
   endtask

   // Shrinking leaves the hand out of range and keeps the upper frames; growing
   // again exposes a page that is resident in two frames.
   task automatic test_shrink_and_grow();
      write_frame_count(CSR_W'(8));
      for (int p = 20; p < 25; p++) send_page(PAGE_ID_W'(p));
      write_frame_count(CSR_W'(3));
      send_page(20'd25);
      send_page(20'd23);
      write_frame_count(CSR_W'(8));
      send_page(20'd23);
   endtask

   // The receiver holds off long enough for the block to fill and stall its input.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_frame_count(CSR_W'(4));
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         begin
            for (int k = 0; k < 24; k++) send_page(PAGE_ID_W'(100 + $urandom_range(5)));
         end
      join
      wait_drained();
   endtask

   task automatic test_random_traffic(int unsigned items, int unsigned send_pct,
                                      int unsigned recv_pct);
      int unsigned        done;
      int unsigned        r;
      int unsigned        n;
      int unsigned        burst;
      bit [CSR_W-1:0]     count;
      bit [PAGE_ID_W-1:0] last_page;
      bit [PAGE_ID_W-1:0] pool[$];
      done = 0;
      last_page = '0;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      while (done < items) begin
         r = $urandom_range(99);
         if (r < 55) count = CSR_W'($urandom_range(1, 8));
         else if (r < 85) count = CSR_W'($urandom_range(9, 32));
         else if (r < 95) count = CSR_W'($urandom_range(33, 128));
         else if (r < 97) count = '0;
         else count = CSR_W'($urandom_range(129, 2047));
         write_frame_count(count);
         n = (count == 0) ? 1 : (count > FRAMES) ? FRAMES : count;
         // Large counts make every transaction slow, so they get short bursts.
         burst = (n > 128) ? 4 : $urandom_range(8, 24);
         pool.delete();
         repeat ((n > 128 ? 128 : n) + n / 2 + 1) pool.push_back(PAGE_ID_W'($urandom));
         for (int k = 0; k < burst; k++) begin
            r = $urandom_range(99);
            if (r < 80) last_page = pool[$urandom_range(pool.size() - 1)];
            else if (r >= 90) last_page = PAGE_ID_W'($urandom);
            send_page(last_page);
            done++;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_full_depth();
      test_count_limits();
      test_second_chance();
      test_shrink_and_grow();
      test_backpressure();
      test_random_traffic(185, 12, 52);
      test_random_traffic(185, 52, 12);
      test_random_traffic(185, 0, 0);
      wait_drained();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
